[rtl/core/art_pkg.sv]
`timescale 1ns / 1ps

package art_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int OP_W     = 2;
   localparam int NUM_W    = 16;
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 16;
   localparam int HANDLE_W = 8;
   localparam int TIME_W   = 32;
   localparam int ATT_W    = 8;
   localparam int KIND_W   = 2;
   localparam int CFG_W    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // opcodes
   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_RECV   = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_RESEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DROP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ACK    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

   // csr map
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ATTEMPTS   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESEND_TIMEOUT = 1'd1;

   localparam logic [CFG_W-1:0] MAX_ATTEMPTS_RESET   = 8'd5;
   localparam logic [CFG_W-1:0] RESEND_TIMEOUT_RESET = 8'd1;

   typedef struct packed {
      logic [NUM_W-1:0]    number;
      logic [TIME_W-1:0]   stamp;
      logic [ATT_W-1:0]    attempts;
      logic [ADDR_W-1:0]   address;
      logic [LEN_W-1:0]    length;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic push;   // load the new entry
      logic shift;  // take the neighbor's entry
      logic bump;   // count one more attempt and restamp
   } cell_ctl_type;

   typedef struct packed {
      logic match;    // number equals the ack key
      logic expired;  // stamp plus timeout below now
   } cell_flags_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [NUM_W-1:0]    number;
      logic [ADDR_W-1:0]   address;
      logic [LEN_W-1:0]    length;
      logic [HANDLE_W-1:0] handle;
      logic [ATT_W-1:0]    attempts;
   } result_type;

endpackage

[rtl/core/art_cell.sv]
`timescale 1ns / 1ps

module art_cell (
   input  logic                         clock,
   input  art_pkg::cell_ctl_type        ctl,
   input  art_pkg::entry_type           push_entry,
   input  art_pkg::entry_type           next_entry,
   input  logic [art_pkg::NUM_W-1:0]    key,
   input  logic [art_pkg::TIME_W-1:0]   now,
   input  logic [art_pkg::CFG_W-1:0]    timeout,
   output art_pkg::entry_type           entry,
   output art_pkg::cell_flags_type      flags
);
   import art_pkg::*;

   entry_type           entry_ff;
   entry_type           entry_in;
   logic [TIME_W:0]     deadline;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         entry_in = push_entry;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end else if (ctl.bump) begin
         entry_in.stamp = now;
         if (entry_ff.attempts != {ATT_W{1'b1}}) begin
            entry_in.attempts = entry_ff.attempts + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // 33-bit sum, no wrap
   assign deadline = {1'b0, entry_ff.stamp} + {{(TIME_W + 1 - CFG_W){1'b0}}, timeout};

   assign flags.match   = (entry_ff.number == key);
   assign flags.expired = (deadline < {1'b0, now});
   assign entry         = entry_ff;

endmodule

[rtl/core/ack_retransmit_table.sv]
// channel   | ports                                         | transfer when
// ----------+-----------------------------------------------+-----------------------
// request   | start, busy, req_*                            | start & ~busy
// response  | rsp_valid, rsp_*                              | rsp_valid (one cycle)
// csr write | csr_valid, csr_ready, csr_index, csr_wdata    | csr_valid & csr_ready
//
// push and unused opcode finish while idle; send ack and push reject pass through flush
// ack removal and tick: the scan pointer walks the cell row one entry per cycle, then
//   goes to flush; a tick also ends at its first resend, a removal holds the pointer
// a result waits in a holding slot until the next result or the flush marks last,
//   so it is registered in the holding slot and then in the response register
// synchronous reset empties the table and restores csr defaults; no clearing pass
// the response side has no back pressure
`timescale 1ns / 1ps

module ack_retransmit_table (
   input  logic                             clock,
   input  logic                             reset,
   // request
   input  logic                             start,
   output logic                             busy,
   input  logic [art_pkg::OP_W-1:0]         req_opcode,
   input  logic [art_pkg::NUM_W-1:0]        req_packet_number,
   input  logic                             req_is_ack,
   input  logic [art_pkg::ADDR_W-1:0]       req_peer_address,
   input  logic [art_pkg::LEN_W-1:0]        req_payload_length,
   input  logic [art_pkg::HANDLE_W-1:0]     req_buffer_handle,
   input  logic [art_pkg::TIME_W-1:0]       req_now_seconds,
   // response
   output logic                             rsp_valid,
   output logic [art_pkg::KIND_W-1:0]       rsp_out_kind,
   output logic [art_pkg::NUM_W-1:0]        rsp_out_number,
   output logic [art_pkg::ADDR_W-1:0]       rsp_out_address,
   output logic [art_pkg::LEN_W-1:0]        rsp_out_length,
   output logic [art_pkg::HANDLE_W-1:0]     rsp_out_handle,
   output logic [art_pkg::ATT_W-1:0]        rsp_out_attempts,
   output logic                             rsp_last,
   // csr write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [art_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [art_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import art_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type            state_ff, state_in;

   // control registers
   logic [CNT_W-1:0]     count_ff, count_in;     // entries held, packed at the low cells
   logic [CNT_W-1:0]     idx_ff, idx_in;         // scan pointer
   logic                 pend_valid_ff, pend_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CFG_W-1:0]     max_attempts_ff, max_attempts_in;
   logic [CFG_W-1:0]     resend_timeout_ff, resend_timeout_in;

   // payload registers
   logic [OP_W-1:0]      op_ff, op_in;
   logic [NUM_W-1:0]     key_ff, key_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   result_type           pend_ff, pend_in;       // newest result, waits to learn if it is last
   result_type           rsp_ff, rsp_in;
   logic                 rsp_last_ff, rsp_last_in;

   // cell row
   entry_type            cell_entry [TABLE_DEPTH];
   cell_flags_type       cell_flags [TABLE_DEPTH];
   cell_ctl_type         cell_ctl   [TABLE_DEPTH];
   entry_type            push_entry;
   entry_type            sel_entry;
   cell_flags_type       sel_flags;

   logic                 accept;
   logic                 push_go;
   logic                 scan_remove;
   logic                 scan_resend;
   logic                 new_res;
   result_type           new_item;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start & ~busy;
   assign csr_ready = 1'b1;

   assign push_entry.number   = req_packet_number;
   assign push_entry.stamp    = req_now_seconds;
   assign push_entry.attempts = '0;
   assign push_entry.address  = req_peer_address;
   assign push_entry.length   = req_payload_length;
   assign push_entry.handle   = req_buffer_handle;

   // entry under the scan pointer
   assign sel_entry = cell_entry[idx_ff[IDX_W-1:0]];
   assign sel_flags = cell_flags[idx_ff[IDX_W-1:0]];

   // row of cells; a removal slides every cell at or above the pointer down by one
   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      entry_type next_entry;

      if (k < TABLE_DEPTH - 1) begin : g_mid
         assign next_entry = cell_entry[k + 1];
      end else begin : g_end
         assign next_entry = cell_entry[k];
      end

      assign cell_ctl[k].push  = push_go && (count_ff == CNT_W'(k));
      assign cell_ctl[k].shift = scan_remove && (CNT_W'(k) >= idx_ff);
      assign cell_ctl[k].bump  = scan_resend && (idx_ff == CNT_W'(k));

      art_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[k]),
         .push_entry (push_entry),
         .next_entry (next_entry),
         .key        (key_ff),
         .now        (now_ff),
         .timeout    (resend_timeout_ff),
         .entry      (cell_entry[k]),
         .flags      (cell_flags[k])
      );
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = 1'b0;
      push_go       = 1'b0;
      scan_remove   = 1'b0;
      scan_resend   = 1'b0;
      new_res       = 1'b0;
      new_item      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_opcode;
               key_in = req_packet_number;
               now_in = req_now_seconds;
               idx_in = '0;
               case (req_opcode)
                  OP_PUSH: begin
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        // table full, echo the push back
                        new_res           = 1'b1;
                        new_item.kind     = KIND_REJECT;
                        new_item.number   = req_packet_number;
                        new_item.address  = req_peer_address;
                        new_item.length   = req_payload_length;
                        new_item.handle   = req_buffer_handle;
                        state_in          = ST_FLUSH;
                     end else begin
                        push_go  = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_RECV: begin
                     if (req_is_ack) begin
                        state_in = ST_SCAN;
                     end else begin
                        new_res          = 1'b1;
                        new_item.kind    = KIND_ACK;
                        new_item.number  = req_packet_number;
                        new_item.address = req_peer_address;
                        state_in         = ST_FLUSH;
                     end
                  end
                  OP_TICK: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (idx_ff >= count_ff) begin
               state_in = ST_FLUSH;
            end else if (op_ff == OP_RECV) begin
               // ack: drop every entry with the key, the pointer holds after a removal
               if (sel_flags.match) begin
                  scan_remove = 1'b1;
                  count_in    = count_ff - 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (sel_flags.expired) begin
               new_res           = 1'b1;
               new_item.number   = sel_entry.number;
               new_item.address  = sel_entry.address;
               new_item.length   = sel_entry.length;
               new_item.handle   = sel_entry.handle;
               new_item.attempts = sel_entry.attempts;
               if (sel_entry.attempts >= max_attempts_ff) begin
                  // attempt limit reached
                  new_item.kind = KIND_DROP;
                  scan_remove   = 1'b1;
                  count_in      = count_ff - 1'b1;
               end else begin
                  // first resend ends the tick
                  new_item.kind = KIND_RESEND;
                  scan_resend   = 1'b1;
                  state_in      = ST_FLUSH;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_in        = pend_ff;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a new result pushes the held one out, not the last
      if (new_res) begin
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         pend_in       = new_item;
         pend_valid_in = 1'b1;
      end
   end

   // csr writes
   always_comb begin
      max_attempts_in   = max_attempts_ff;
      resend_timeout_in = resend_timeout_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_ATTEMPTS:   max_attempts_in   = csr_wdata;
            CSR_RESEND_TIMEOUT: resend_timeout_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         count_ff          <= '0;
         idx_ff            <= '0;
         pend_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         max_attempts_ff   <= MAX_ATTEMPTS_RESET;
         resend_timeout_ff <= RESEND_TIMEOUT_RESET;
      end else begin
         state_ff          <= state_in;
         count_ff          <= count_in;
         idx_ff            <= idx_in;
         pend_valid_ff     <= pend_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         max_attempts_ff   <= max_attempts_in;
         resend_timeout_ff <= resend_timeout_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      now_ff      <= now_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_kind     = rsp_ff.kind;
   assign rsp_out_number   = rsp_ff.number;
   assign rsp_out_address  = rsp_ff.address;
   assign rsp_out_length   = rsp_ff.length;
   assign rsp_out_handle   = rsp_ff.handle;
   assign rsp_out_attempts = rsp_ff.attempts;
   assign rsp_last         = rsp_last_ff;

endmodule

[bench/tb_ack_retransmit_table.sv]
`timescale 1ns / 1ps

module tb_ack_retransmit_table;
   import art_pkg::*;

   // one request as the driver presents it
   typedef struct packed {
      logic [OP_W-1:0]     opcode;
      logic [NUM_W-1:0]    number;
      logic                is_ack;
      logic [ADDR_W-1:0]   address;
      logic [LEN_W-1:0]    length;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   now;
   } request_type;

   // one predicted response, with its end-of-request marker
   typedef struct packed {
      result_type body;
      logic       last;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [NUM_W-1:0]    req_packet_number = '0;
   logic                req_is_ack = 1'b0;
   logic [ADDR_W-1:0]   req_peer_address = '0;
   logic [LEN_W-1:0]    req_payload_length = '0;
   logic [HANDLE_W-1:0] req_buffer_handle = '0;
   logic [TIME_W-1:0]   req_now_seconds = '0;

   // response channel
   logic                rsp_valid;
   logic [KIND_W-1:0]   rsp_out_kind;
   logic [NUM_W-1:0]    rsp_out_number;
   logic [ADDR_W-1:0]   rsp_out_address;
   logic [LEN_W-1:0]    rsp_out_length;
   logic [HANDLE_W-1:0] rsp_out_handle;
   logic [ATT_W-1:0]    rsp_out_attempts;
   logic                rsp_last;

   // csr write channel
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ack_retransmit_table dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_packet_number  (req_packet_number),
      .req_is_ack         (req_is_ack),
      .req_peer_address   (req_peer_address),
      .req_payload_length (req_payload_length),
      .req_buffer_handle  (req_buffer_handle),
      .req_now_seconds    (req_now_seconds),
      .rsp_valid          (rsp_valid),
      .rsp_out_kind       (rsp_out_kind),
      .rsp_out_number     (rsp_out_number),
      .rsp_out_address    (rsp_out_address),
      .rsp_out_length     (rsp_out_length),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_attempts   (rsp_out_attempts),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // shadow copy of the retransmit table, packed oldest first
   entry_type   kept [TABLE_DEPTH];
   int unsigned kept_count = 0;
   logic [CFG_W-1:0] max_att_cfg = MAX_ATTEMPTS_RESET;
   logic [CFG_W-1:0] timeout_cfg = RESEND_TIMEOUT_RESET;

   request_type request_queue [$];   // requests waiting for the driver
   outcome_type due_results [$];     // responses predicted but not yet seen
   request_type current_req;         // request on the port right now
   outcome_type oldest;
   int       idle_pct = 28;       // chance in 100 that the driver holds off when it could present a request
   int       mismatch_count = 0;
   logic [TIME_W-1:0] wall_seconds = '0;   // running notion of current time

   // clock and the single reset at the start
   initial begin
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // take out one table entry, later entries slide down one slot
   function automatic void drop_entry(int unsigned pos);
      for (int unsigned k = pos; k + 1 < kept_count; k++) begin
         kept[k] = kept[k + 1];
      end
      kept_count--;
   endfunction

   // apply one accepted request to the shadow table, queue the responses it causes
   function automatic void update_shadow_table(request_type rq);
      result_type       found [$];
      outcome_type      o;
      int unsigned      i;
      logic [TIME_W:0]  deadline;
      case (rq.opcode)
         OP_PUSH: begin
            if (kept_count >= TABLE_DEPTH) begin
               // full table: echo the push back as a reject
               found.insert(found.size(), '{kind: KIND_REJECT, number: rq.number,
                                            address: rq.address, length: rq.length,
                                            handle: rq.handle, attempts: '0});
            end else begin
               kept[kept_count] = '{number: rq.number, stamp: rq.now, attempts: '0,
                                    address: rq.address, length: rq.length,
                                    handle: rq.handle};
               kept_count++;
            end
         end
         OP_RECV: begin
            if (rq.is_ack) begin
               // every entry carrying this number goes, duplicates too
               i = 0;
               while (i < kept_count) begin
                  if (kept[i].number == rq.number) drop_entry(i);
                  else i++;
               end
            end else begin
               found.insert(found.size(), '{kind: KIND_ACK, number: rq.number,
                                            address: rq.address, length: '0,
                                            handle: '0, attempts: '0});
            end
         end
         OP_TICK: begin
            i = 0;
            while (i < kept_count) begin
               // stamp + timeout < now, computed one bit wider so it never wraps
               deadline = {1'b0, kept[i].stamp} +
                          {{(TIME_W + 1 - CFG_W){1'b0}}, timeout_cfg};
               if (deadline >= {1'b0, rq.now}) begin
                  i++;
               end else if (kept[i].attempts >= max_att_cfg) begin
                  found.insert(found.size(), '{kind: KIND_DROP, number: kept[i].number,
                                               address: kept[i].address,
                                               length: kept[i].length,
                                               handle: kept[i].handle,
                                               attempts: kept[i].attempts});
                  drop_entry(i);
               end else begin
                  // first live timeout is resent and ends the scan
                  found.insert(found.size(), '{kind: KIND_RESEND, number: kept[i].number,
                                               address: kept[i].address,
                                               length: kept[i].length,
                                               handle: kept[i].handle,
                                               attempts: kept[i].attempts});
                  if (kept[i].attempts != 8'hFF) kept[i].attempts++;
                  kept[i].stamp = rq.now;
                  break;
               end
            end
         end
         default: ;   // unused opcode does nothing
      endcase
      foreach (found[k]) begin
         o.body = found[k];
         o.last = (k == found.size() - 1);
         due_results = {due_results, o};
      end
   endfunction

   // request with random side fields, the rest given
   function automatic request_type make_request(logic [OP_W-1:0] op,
                                                logic [NUM_W-1:0] number,
                                                logic is_ack, logic [TIME_W-1:0] now);
      request_type rq;
      rq.opcode  = op;
      rq.number  = number;
      rq.is_ack  = is_ack;
      rq.address = $urandom;
      rq.length  = LEN_W'($urandom_range(0, 65535));
      rq.handle  = HANDLE_W'($urandom_range(0, 255));
      rq.now     = now;
      return rq;
   endfunction

   // packet numbers mostly from a small pool so acks hit live entries
   function automatic logic [NUM_W-1:0] pick_number();
      if ($urandom_range(99) < 20) return NUM_W'($urandom_range(0, 65535));
      return NUM_W'($urandom_range(0, 5));
   endfunction

   // one random request, shaped like real traffic most of the time
   function automatic request_type random_request();
      int roll;
      roll = $urandom_range(99);
      if (roll < 35) begin
         return make_request(OP_PUSH, pick_number(), 1'($urandom_range(1)), wall_seconds);
      end else if (roll < 65) begin
         wall_seconds = wall_seconds + $urandom_range(0, 2 * timeout_cfg + 3);
         return make_request(OP_TICK, pick_number(), 1'($urandom_range(1)), wall_seconds);
      end else if (roll < 83) begin
         return make_request(OP_RECV, pick_number(), 1'b1, $urandom);
      end else if (roll < 91) begin
         return make_request(OP_RECV, NUM_W'($urandom_range(0, 65535)), 1'b0, $urandom);
      end else if (roll < 97) begin
         // noise: any time at all, far past or far ahead
         return make_request(OP_W'($urandom_range(0, 2)), NUM_W'($urandom_range(0, 65535)),
                             1'($urandom_range(1)), $urandom);
      end
      return make_request(OP_UNUSED, NUM_W'($urandom_range(0, 65535)),
                          1'($urandom_range(1)), $urandom);
   endfunction

   // csr write, only called while the block is idle
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MAX_ATTEMPTS) max_att_cfg = value;
      else timeout_cfg = value;
      csr_valid <= 1'b0;
   endtask

   // everything sent and answered, then let an ack removal scan run out
   task automatic wait_idle();
      do @(negedge clock);
      while (request_queue.size() != 0 || start || busy || due_results.size() != 0);
      repeat (TABLE_DEPTH + 4) @(negedge clock);
   endtask

   // driver: present the next request once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) update_shadow_table(current_req);
         if (!start || !busy) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               current_req = request_queue.pop_front();
               start              <= 1'b1;
               req_opcode         <= current_req.opcode;
               req_packet_number  <= current_req.number;
               req_is_ack         <= current_req.is_ack;
               req_peer_address   <= current_req.address;
               req_payload_length <= current_req.length;
               req_buffer_handle  <= current_req.handle;
               req_now_seconds    <= current_req.now;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // monitor: every strobed response is a transfer, compare with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (due_results.size() == 0) begin
            $error("response with nothing expected: kind %0d number 0x%0h",
                   rsp_out_kind, rsp_out_number);
            mismatch_count++;
         end else begin
            oldest = due_results.pop_front();
            check_field("out_kind", 32'(oldest.body.kind), 32'(rsp_out_kind));
            check_field("out_number", 32'(oldest.body.number), 32'(rsp_out_number));
            check_field("out_address", oldest.body.address, rsp_out_address);
            check_field("out_length", 32'(oldest.body.length), 32'(rsp_out_length));
            check_field("out_handle", 32'(oldest.body.handle), 32'(rsp_out_handle));
            check_field("out_attempts", 32'(oldest.body.attempts), 32'(rsp_out_attempts));
            check_field("last", 32'(oldest.last), 32'(rsp_last));
         end
      end
   end

   // stimulus sequence
   initial begin
      request_type rq;
      logic [CFG_W-1:0] phase_max [5];
      logic [CFG_W-1:0] phase_timeout [5];
      int               phase_idle [5];

      phase_max     = '{8'd0, 8'd255, 8'd2, 8'd1, 8'd5};
      phase_timeout = '{8'd0, 8'd255, 8'd3, 8'd0, 8'd1};
      phase_idle    = '{28, 28, 0, 28, 28};   // third phase runs without any gaps

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset defaults for the csrs
      // tick on an empty table at time zero
      request_queue = {request_queue, make_request(OP_TICK, 16'h0000, 1'b0, 32'h0)};
      // send-ack with all-ones and all-zero fields
      rq = make_request(OP_RECV, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
      rq.address = 32'hFFFF_FFFF;
      request_queue = {request_queue, rq};
      rq = make_request(OP_RECV, 16'h0000, 1'b0, 32'h0);
      rq.address = '0;
      request_queue = {request_queue, rq};
      // unused opcode is ignored
      request_queue = {request_queue, make_request(OP_UNUSED, 16'hFFFF, 1'b1, 32'hFFFF_FFFF)};
      // fill the table, numbers repeat so one ack clears several
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         rq = make_request(OP_PUSH, 16'(k % 4), 1'b0, 32'd100);
         if (k == 0) begin
            rq.address = '0;
            rq.length  = '0;
            rq.handle  = '0;
         end else if (k == 1) begin
            rq.address = 32'hFFFF_FFFF;
            rq.length  = 16'hFFFF;
            rq.handle  = 8'hFF;
         end else if (k == TABLE_DEPTH - 1) begin
            rq.now = 32'hFFFF_FFFF;   // stamp that can never time out
         end
         request_queue = {request_queue, rq};
      end
      // push into a full table is rejected
      request_queue = {request_queue, make_request(OP_PUSH, 16'hABCD, 1'b1, 32'd100)};
      // ack removes all four entries numbered 3
      request_queue = {request_queue, make_request(OP_RECV, 16'd3, 1'b1, 32'd0)};
      // exactly at the timeout edge: nothing, then resends of the oldest
      request_queue = {request_queue, make_request(OP_TICK, 16'd0, 1'b0, 32'd101)};
      request_queue = {request_queue, make_request(OP_TICK, 16'd0, 1'b0, 32'd110)};
      request_queue = {request_queue, make_request(OP_TICK, 16'd0, 1'b0, 32'd200)};
      wall_seconds = 32'd200;
      wait_idle();

      // random phases, each under its own csr setting
      for (int p = 0; p < 5; p++) begin
         write_register(CSR_MAX_ATTEMPTS, phase_max[p]);
         write_register(CSR_RESEND_TIMEOUT, phase_timeout[p]);
         idle_pct = phase_idle[p];
         for (int n = 0; n < 19; n++) begin
            request_queue = {request_queue, random_request()};
         end
         wait_idle();
      end

      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[ack_retransmit_table.f]
rtl/core/art_pkg.sv
rtl/core/art_cell.sv
rtl/core/ack_retransmit_table.sv
bench/tb_ack_retransmit_table.sv
